>>> rtl/core/lru_ol_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_ol_pkg: shared types and codes of the LRU order list
// Mode codes and the packed payload types of the request and result channels.
// ----------------------------------------------------------------------------
package lru_ol_pkg;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_TOUCH  = 2'd1;
  localparam logic [1:0] MODE_PULL   = 2'd2;
  localparam logic [1:0] MODE_PEEK   = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] entry_index;
  } lru_ol_in_t;

  typedef struct packed {
    logic [3:0] result_entry;
    logic       result_valid;
    logic       list_empty;
  } lru_ol_out_t;

endpackage : lru_ol_pkg
`default_nettype wire

>>> rtl/core/lru_ol_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_ol_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lru_ol_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : lru_ol_ram
`default_nettype wire

>>> rtl/core/lru_ol_links.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_ol_links: one link array of the order list
// Link RAM plus a written bit per entry; an entry never written since reset
// reads as its start-up link in ascending order.
// ----------------------------------------------------------------------------
module lru_ol_links #(
  parameter int ENTRIES = 16,
  parameter bit IS_NEXT = 1'b0
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           rd_en,
  input  wire logic                           wr_en,
  input  wire logic [$clog2(ENTRIES)-1:0]     addr,
  input  wire logic [$clog2(ENTRIES+1)-1:0]   wdata,
  output logic      [$clog2(ENTRIES+1)-1:0]   rd_link
);

  localparam int IW = $clog2(ENTRIES);
  localparam int LW = $clog2(ENTRIES + 1);
  localparam logic [LW-1:0] NONE_LINK = LW'(ENTRIES);
  localparam logic [IW-1:0] LAST_IDX  = IW'(ENTRIES - 1);

  logic [ENTRIES-1:0] written_r;
  logic               rd_written_r;
  logic [IW-1:0]      rd_addr_r;
  logic [LW-1:0]      ram_rdata;
  logic [LW-1:0]      start_link;

  lru_ol_ram #(
    .WIDTH (LW),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (addr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r    <= '0;
      rd_written_r <= 1'b0;
    end else begin
      if (wr_en) begin
        written_r[addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_written_r <= written_r[addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_addr_r <= addr;
    end
  end

  always_comb begin
    if (IS_NEXT) begin
      start_link = (rd_addr_r == LAST_IDX) ? NONE_LINK : LW'(rd_addr_r) + LW'(1);
    end else begin
      start_link = (rd_addr_r == '0) ? NONE_LINK : LW'(rd_addr_r) - LW'(1);
    end
  end

  assign rd_link = rd_written_r ? ram_rdata : start_link;

endmodule : lru_ol_links
`default_nettype wire

>>> rtl/core/lru_order_list.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_order_list: recency order over a fixed pool of entries
// Doubly linked list in two link RAMs, walked by a small sequencer.
// ----------------------------------------------------------------------------
// The list starts full, entry 0 at the head and the last entry at the tail;
// no clearing pass is needed because never-written links read as their
// start-up values. A request is taken when start is high and busy is low,
// and its result appears on out_data for exactly one cycle with out_valid;
// the receiver cannot stall it. Each link array drives one address to both
// ports of its RAM, so the work is spread over states: peek and requests
// that change nothing report straight from idle, pull of the only member
// goes to S_CLR, insert to S_FRONT and, unless the list was empty, S_HEADP,
// pull through S_RD, S_LINK and S_CLR, and move to front through S_RD,
// S_LINK, S_FRONT and S_HEADP. The next request can be taken in the same cycle that the result is shown.
// ----------------------------------------------------------------------------
module lru_order_list
  import lru_ol_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire lru_ol_in_t  in_data,
  output logic             busy,
  output logic             out_valid,
  output lru_ol_out_t      out_data
);

  localparam int IW = $clog2(ENTRIES);
  localparam int LW = $clog2(ENTRIES + 1);
  localparam logic [LW-1:0] NONE_LINK = LW'(ENTRIES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_LINK  = 3'd2;
  localparam logic [2:0] S_FRONT = 3'd3;
  localparam logic [2:0] S_HEADP = 3'd4;
  localparam logic [2:0] S_CLR   = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [1:0]         op_r, op_nxt;
  logic [IW-1:0]      ent_r, ent_nxt;
  logic               single_r, single_nxt;
  logic [LW-1:0]      head_r, head_nxt;
  logic [LW-1:0]      tail_r, tail_nxt;
  logic [ENTRIES-1:0] in_list_r, in_list_nxt;
  logic               out_valid_r, out_valid_nxt;
  lru_ol_out_t        out_data_r, out_data_nxt;

  logic               prev_rd, prev_we, next_rd, next_we;
  logic [IW-1:0]      prev_addr, next_addr;
  logic [LW-1:0]      prev_wdata, next_wdata;
  logic [LW-1:0]      prev_link, next_link;

  logic               e_ok;
  logic [IW-1:0]      e_idx;

  lru_ol_links #(
    .ENTRIES (ENTRIES),
    .IS_NEXT (1'b0)
  ) u_prev (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (prev_rd),
    .wr_en   (prev_we),
    .addr    (prev_addr),
    .wdata   (prev_wdata),
    .rd_link (prev_link)
  );

  lru_ol_links #(
    .ENTRIES (ENTRIES),
    .IS_NEXT (1'b1)
  ) u_next (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (next_rd),
    .wr_en   (next_we),
    .addr    (next_addr),
    .wdata   (next_wdata),
    .rd_link (next_link)
  );

  assign e_ok  = 32'(in_data.entry_index) < 32'(ENTRIES);
  assign e_idx = IW'(in_data.entry_index);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    ent_nxt       = ent_r;
    single_nxt    = single_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    in_list_nxt   = in_list_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    prev_rd       = 1'b0;
    prev_we       = 1'b0;
    prev_addr     = ent_r;
    prev_wdata    = NONE_LINK;
    next_rd       = 1'b0;
    next_we       = 1'b0;
    next_addr     = ent_r;
    next_wdata    = NONE_LINK;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt  = in_data.mode;
          ent_nxt = e_idx;
          // Requests that change nothing report right away.
          out_data_nxt.result_entry = '0;
          out_data_nxt.result_valid = 1'b0;
          out_data_nxt.list_empty   = (head_r == NONE_LINK);
          unique case (in_data.mode)
            MODE_INSERT: begin
              if (e_ok && !in_list_r[e_idx]) begin
                state_nxt = S_FRONT;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            MODE_TOUCH: begin
              if (e_ok && in_list_r[e_idx] && (head_r != LW'(in_data.entry_index))) begin
                state_nxt = S_RD;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            MODE_PULL: begin
              if (head_r == NONE_LINK) begin
                out_valid_nxt = 1'b1;
              end else begin
                ent_nxt    = IW'(tail_r);
                single_nxt = (head_r == tail_r);
                state_nxt  = (head_r == tail_r) ? S_CLR : S_RD;
              end
            end
            MODE_PEEK: begin
              out_valid_nxt = 1'b1;
              if (head_r != NONE_LINK) begin
                out_data_nxt.result_entry = 4'(tail_r);
                out_data_nxt.result_valid = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_RD: begin
        prev_rd   = 1'b1;
        next_rd   = 1'b1;
        state_nxt = S_LINK;
      end
      S_LINK: begin
        // Unlink: on touch its neighbors point at each other; on pull its predecessor is the new tail.
        next_we   = 1'b1;
        next_addr = IW'(prev_link);
        if (op_r == MODE_TOUCH) begin
          next_wdata = next_link;
          if (next_link == NONE_LINK) begin
            tail_nxt = prev_link;
          end else begin
            prev_we    = 1'b1;
            prev_addr  = IW'(next_link);
            prev_wdata = prev_link;
          end
          state_nxt = S_FRONT;
        end else begin
          next_wdata = NONE_LINK;
          tail_nxt   = prev_link;
          state_nxt  = S_CLR;
        end
      end
      S_FRONT: begin
        prev_we    = 1'b1;
        prev_wdata = NONE_LINK;
        next_we    = 1'b1;
        next_wdata = head_r;
        if (head_r == NONE_LINK) begin
          head_nxt                  = LW'(ent_r);
          tail_nxt                  = LW'(ent_r);
          in_list_nxt[ent_r]        = 1'b1;
          out_valid_nxt             = 1'b1;
          out_data_nxt.result_entry = '0;
          out_data_nxt.result_valid = 1'b0;
          out_data_nxt.list_empty   = 1'b0;
          state_nxt                 = S_IDLE;
        end else begin
          state_nxt = S_HEADP;
        end
      end
      S_HEADP: begin
        prev_we                   = 1'b1;
        prev_addr                 = IW'(head_r);
        prev_wdata                = LW'(ent_r);
        head_nxt                  = LW'(ent_r);
        in_list_nxt[ent_r]        = 1'b1;
        out_valid_nxt             = 1'b1;
        out_data_nxt.result_entry = '0;
        out_data_nxt.result_valid = 1'b0;
        out_data_nxt.list_empty   = 1'b0;
        state_nxt                 = S_IDLE;
      end
      S_CLR: begin
        prev_we            = 1'b1;
        next_we            = 1'b1;
        in_list_nxt[ent_r] = 1'b0;
        if (single_r) begin
          head_nxt = NONE_LINK;
          tail_nxt = NONE_LINK;
        end
        out_valid_nxt             = 1'b1;
        out_data_nxt.result_entry = 4'(ent_r);
        out_data_nxt.result_valid = 1'b1;
        out_data_nxt.list_empty   = single_r;
        state_nxt                 = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= LW'(ENTRIES - 1);
      in_list_r   <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      in_list_r   <= in_list_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    ent_r      <= ent_nxt;
    single_r   <= single_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // A result is only shown once the sequencer has returned to idle.
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while sequencer busy");

  // Head and tail are empty together or not at all.
  a_head_tail_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == NONE_LINK) == (tail_r == NONE_LINK))
    else $error("head and tail disagree on empty list");

  // The reported empty flag matches the list as it now stands.
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.list_empty == (head_r == NONE_LINK)))
    else $error("list_empty does not match head pointer");

  // Link data read in one cycle is consumed in the next.
  a_read_then_link: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |=> (state_r == S_LINK))
    else $error("link read not followed by link update");
`endif

endmodule : lru_order_list
`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the LRU order list
// A queue-fed driver sends insert, touch, pull and peek requests under random
// start gaps. A clocked monitor keeps its own copy of the linked list, predicts
// the result of every accepted request and compares each returned result.
// ----------------------------------------------------------------------------
module testbench;
  import lru_ol_pkg::*;

  localparam int          N_ENTRIES    = 16;
  localparam logic [4:0]  NO_LINK      = 5'd16;
  localparam int          RANDOM_ITEMS = 1150;
  localparam int          SETTLE_CYCLES = 8;

  typedef struct {
    lru_ol_in_t req;
    bit         drain_first;
  } queued_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  lru_ol_in_t  in_data = '0;
  logic        busy;
  logic        out_valid;
  lru_ol_out_t out_data;

  // Shadow copy of the recency list.
  logic [4:0]  prev_l [N_ENTRIES];
  logic [4:0]  next_l [N_ENTRIES];
  bit          member [N_ENTRIES];
  logic [4:0]  head_p;
  logic [4:0]  tail_p;

  queued_req_t pending_q[$];
  lru_ol_out_t list_outcomes_q[$];

  int total_items = 0;
  int sent_cnt = 0;
  int done_cnt = 0;
  int mismatches = 0;
  int mode_tally [4];
  int tail_reports = 0;
  int empty_reports = 0;

  lru_order_list #(.ENTRIES(N_ENTRIES)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_data  (in_data),
    .busy     (busy),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  function automatic void clear_list();
    for (int i = 0; i < N_ENTRIES; i++) begin
      prev_l[i] = (i == 0) ? NO_LINK : 5'(i - 1);
      next_l[i] = (i == N_ENTRIES - 1) ? NO_LINK : 5'(i + 1);
      member[i] = 1'b1;
    end
    head_p = 5'd0;
    tail_p = 5'(N_ENTRIES - 1);
  endfunction

  function automatic void link_at_front(logic [4:0] e);
    prev_l[e] = NO_LINK;
    next_l[e] = head_p;
    if (head_p == NO_LINK) begin
      tail_p = e;
    end else begin
      prev_l[head_p] = e;
    end
    head_p = e;
  endfunction

  // Applies one request to the shadow list and returns the result it yields.
  function automatic lru_ol_out_t advance_list(lru_ol_in_t req);
    lru_ol_out_t r;
    logic [4:0]  e;
    logic [4:0]  p;
    logic [4:0]  n;
    logic [4:0]  t;
    r = '0;
    e = {1'b0, req.entry_index};
    case (req.mode)
      MODE_INSERT: begin
        if (e < N_ENTRIES && !member[e]) begin
          link_at_front(e);
          member[e] = 1'b1;
        end
      end
      MODE_TOUCH: begin
        if (e < N_ENTRIES && member[e] && head_p != e) begin
          p = prev_l[e];
          n = next_l[e];
          if (p != NO_LINK) next_l[p] = n;
          // Touching the tail hands the tail over to its predecessor.
          if (n == NO_LINK) begin
            tail_p = p;
          end else begin
            prev_l[n] = p;
          end
          link_at_front(e);
        end
      end
      default: begin
        if (head_p != NO_LINK) begin
          t = tail_p;
          r.result_entry = t[3:0];
          r.result_valid = 1'b1;
          if (req.mode == MODE_PULL) begin
            if (head_p == tail_p) begin
              head_p = NO_LINK;
              tail_p = NO_LINK;
            end else begin
              p = prev_l[t];
              next_l[p] = NO_LINK;
              tail_p = p;
            end
            prev_l[t] = NO_LINK;
            next_l[t] = NO_LINK;
            member[t] = 1'b0;
          end
        end
      end
    endcase
    r.list_empty = (head_p == NO_LINK);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic add_req(logic [1:0] mode, int idx, bit drain_first);
    queued_req_t q;
    q.req.mode = mode;
    q.req.entry_index = 4'(idx);
    q.drain_first = drain_first;
    pending_q.push_back(q);
  endtask

  // Random traffic comes in runs: drain runs empty the list, fill runs refill
  // it, touch runs shuffle the order, and noise runs mix everything.
  task automatic add_random_run(int kind, int len, bit drain_first);
    int pick;
    logic [1:0] mode;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      case (kind)
        0: mode = (pick < 85) ? MODE_PULL : MODE_PEEK;
        1: mode = (pick < 85) ? MODE_INSERT : MODE_PEEK;
        2: mode = (pick < 70) ? MODE_TOUCH : (pick < 85) ? MODE_INSERT :
                  (pick < 95) ? MODE_PULL : MODE_PEEK;
        default: mode = 2'($urandom_range(3));
      endcase
      add_req(mode, $urandom_range(15), drain_first && i == 0);
    end
  endtask

  initial begin
    int left;
    int len;
    clear_list();

    // Directed opening on the full start-up list.
    add_req(MODE_PEEK,   15, 1'b0);
    add_req(MODE_INSERT, 5,  1'b0);  // already a member
    add_req(MODE_INSERT, 15, 1'b0);  // already a member
    add_req(MODE_TOUCH,  0,  1'b0);  // head stays put
    add_req(MODE_TOUCH,  15, 1'b0);  // tail moves to the front
    add_req(MODE_PEEK,   0,  1'b0);
    add_req(MODE_TOUCH,  7,  1'b0);  // middle entry
    add_req(MODE_PULL,   15, 1'b0);
    add_req(MODE_PULL,   0,  1'b0);
    add_req(MODE_TOUCH,  14, 1'b0);  // no longer a member
    add_req(MODE_INSERT, 14, 1'b0);
    add_req(MODE_INSERT, 13, 1'b0);
    add_req(MODE_TOUCH,  13, 1'b0);
    add_req(MODE_TOUCH,  12, 1'b0);  // current tail
    add_req(MODE_PULL,   9,  1'b0);
    add_req(MODE_PEEK,   6,  1'b0);

    // First random run empties the list so empty pulls and peeks show early.
    add_random_run(0, 20, 1'b1);
    left = RANDOM_ITEMS - 20;
    while (left > 0) begin
      len = $urandom_range(8, 24);
      if (len > left) len = left;
      add_random_run($urandom_range(3), len, $urandom_range(7) == 0);
      left -= len;
    end
    total_items = pending_q.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Driver: holds a request until it is taken, then picks the next one.
  always @(posedge clk) begin
    bit took;
    int idle_pct;
    took = start && !busy;
    if (!rst_n) begin
      start <= 1'b0;
      in_data <= '0;
    end else begin
      if (took) begin
        void'(pending_q.pop_front());
        sent_cnt <= sent_cnt + 1;
      end
      if (start && !took) begin
        // Request still waiting for the block.
      end else if (pending_q.size() == 0) begin
        start <= 1'b0;
      end else begin
        if (sent_cnt < total_items / 3) begin
          idle_pct = 18;
        end else if (sent_cnt < 2 * total_items / 3) begin
          idle_pct = 75;
        end else begin
          idle_pct = 0;
        end
        if (pending_q[0].drain_first &&
            (busy || sent_cnt + int'(took) != done_cnt)) begin
          start <= 1'b0;
        end else if ($urandom_range(99) < idle_pct) begin
          start <= 1'b0;
          in_data <= lru_ol_in_t'($urandom_range(63));
        end else begin
          start <= 1'b1;
          in_data <= pending_q[0].req;
        end
      end
    end
  end

  // Monitor: checks each result, then records the prediction for any
  // transfer completed at this edge.
  always @(posedge clk) begin
    lru_ol_out_t want;
    if (rst_n) begin
      if (out_valid) begin
        done_cnt <= done_cnt + 1;
        if (list_outcomes_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %p", out_data));
        end else begin
          want = list_outcomes_q.pop_front();
          if (out_data.result_entry != want.result_entry)
            report_mismatch($sformatf("result_entry %0d, expected %0d",
                                      out_data.result_entry, want.result_entry));
          if (out_data.result_valid != want.result_valid)
            report_mismatch($sformatf("result_valid %0b, expected %0b",
                                      out_data.result_valid, want.result_valid));
          if (out_data.list_empty != want.list_empty)
            report_mismatch($sformatf("list_empty %0b, expected %0b",
                                      out_data.list_empty, want.list_empty));
        end
      end
      if (start && !busy) begin
        want = advance_list(in_data);
        list_outcomes_q.push_back(want);
        mode_tally[in_data.mode]++;
        if (in_data.mode == MODE_PULL || in_data.mode == MODE_PEEK) begin
          if (want.result_valid) tail_reports++;
          else empty_reports++;
        end
      end
    end
  end

  initial begin
    int waited;
    @(posedge rst_n);
    while (sent_cnt != total_items || total_items == 0) @(posedge clk);
    waited = 0;
    while (list_outcomes_q.size() != 0 && waited < 200) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (list_outcomes_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", list_outcomes_q.size()));
    $display("Sent %0d requests: %0d inserts, %0d touches, %0d pulls, %0d peeks.",
             total_items, mode_tally[MODE_INSERT], mode_tally[MODE_TOUCH],
             mode_tally[MODE_PULL], mode_tally[MODE_PEEK]);
    $display("Tail reported %0d times, empty list reported %0d times, %0d mismatches.",
             tail_reports, empty_reports, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Run timed out with %0d of %0d requests sent.", sent_cnt, total_items);
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> files.f
rtl/core/lru_ol_pkg.sv
rtl/core/lru_ol_ram.sv
rtl/core/lru_ol_links.sv
rtl/core/lru_order_list.sv
dv/testbench.sv
